// File: src/tta_pkg.sv
`default_nettype none

package tta_pkg;

    localparam int TASK_W = 22;
    localparam int TIME_W = 64;
    localparam int OP_W = 3;
    localparam int IN_DATA_W = 136;
    localparam int OUT_DATA_W = 384;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

    localparam logic [TASK_W-1:0] TARGET_TASK_RESET = TASK_W'(2069);

    // word index of the register, taken from paddr[2]
    localparam logic REG_TARGET_TASK = 1'b0;

    typedef enum logic [OP_W-1:0] {
        OP_SWITCH        = 3'd0,
        OP_SYSCALL_ENTRY = 3'd1,
        OP_USER_RETURN   = 3'd2,
        OP_SOFTIRQ_ENTRY = 3'd3,
        OP_SOFTIRQ_EXIT  = 3'd4,
        OP_IRQ_ENTRY     = 3'd5,
        OP_IRQ_EXIT      = 3'd6
    } op_t;

endpackage

`default_nettype wire

// File: src/task_time_accounting_core.sv
`default_nettype none

// Time accounting for one target task (register target_task at byte address 0).
// Each event transaction on the slave side yields exactly one result transaction
// carrying the six 64-bit totals after that event. An accepted event is held in an
// input register; the accumulator update (one 64-bit subtract and add per total)
// and the result register load happen together when the event advances out of it,
// so one event per cycle is sustained while results are taken. s_tready drops only
// when both the input register and the result register are full and the result
// is not taken. Write target_task only while no events are in flight.
module task_time_accounting_core (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // apb configuration port
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [tta_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [tta_pkg::APB_DATA_W-1:0] pwdata,
    output      logic [tta_pkg::APB_DATA_W-1:0] prdata,
    output      logic                           pready,
    // event stream
    input  wire logic                           s_tvalid,
    output      logic                           s_tready,
    // timestamp[63:0], prev_task[85:64], next_task[107:86], current_task[129:108], zero pad
    input  wire logic [tta_pkg::IN_DATA_W-1:0]  s_tdata,
    // op[2:0]
    input  wire logic [tta_pkg::OP_W-1:0]       s_tuser,
    // result stream
    output      logic                           m_tvalid,
    input  wire logic                           m_tready,
    // switch_in_count[63:0], run_time_total[127:64], syscall_time_total[191:128],
    // user_time_total[255:192], softirq_time_total[319:256], irq_time_total[383:320]
    output      logic [tta_pkg::OUT_DATA_W-1:0] m_tdata
);

    localparam int TW = tta_pkg::TIME_W;
    localparam int KW = tta_pkg::TASK_W;

    // configuration
    logic [KW-1:0] target_task_reg;
    logic          cfg_write;

    assign pready = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready
                       && (paddr[2] == tta_pkg::REG_TARGET_TASK);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_task_reg <= tta_pkg::TARGET_TASK_RESET;
        end
        else if (cfg_write)
        begin
            target_task_reg <= pwdata[KW-1:0];
        end
    end

    always_comb
    begin
        if (paddr[2] == tta_pkg::REG_TARGET_TASK)
        begin
            prdata = {{(tta_pkg::APB_DATA_W - KW){1'b0}}, target_task_reg};
        end
        else
        begin
            prdata = '0;
        end
    end

    // input register
    logic          in_valid_reg;
    tta_pkg::op_t  op_reg;
    logic [TW-1:0] ts_reg;
    logic [KW-1:0] prev_reg;
    logic [KW-1:0] next_reg;
    logic [KW-1:0] cur_reg;

    logic          m_tvalid_reg;
    logic [tta_pkg::OUT_DATA_W-1:0] m_tdata_reg;

    logic advance;
    logic in_take;

    assign advance  = in_valid_reg && (!m_tvalid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign in_take  = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            op_reg   <= tta_pkg::op_t'(s_tuser);
            ts_reg   <= s_tdata[TW-1:0];
            prev_reg <= s_tdata[TW +: KW];
            next_reg <= s_tdata[TW + KW +: KW];
            cur_reg  <= s_tdata[TW + 2*KW +: KW];
        end
    end

    // accounting state
    logic [TW-1:0] switch_counter_reg, switch_counter_next;
    logic [TW-1:0] run_start_reg, run_start_next;
    logic [TW-1:0] run_accum_reg, run_accum_next;
    logic [TW-1:0] syscall_start_reg, syscall_start_next;
    logic          in_syscall_reg, in_syscall_next;
    logic [TW-1:0] syscall_accum_reg, syscall_accum_next;
    logic [TW-1:0] user_start_reg, user_start_next;
    logic          in_user_mode_reg, in_user_mode_next;
    logic [TW-1:0] user_accum_reg, user_accum_next;
    logic [TW-1:0] softirq_start_reg, softirq_start_next;
    logic [TW-1:0] softirq_accum_reg, softirq_accum_next;
    logic [TW-1:0] irq_start_reg, irq_start_next;
    logic [TW-1:0] irq_accum_reg, irq_accum_next;

    logic prev_is;
    logic next_is;
    logic cur_is;
    logic switch_hit;

    assign prev_is    = (prev_reg == target_task_reg);
    assign next_is    = (next_reg == target_task_reg);
    assign cur_is     = (cur_reg == target_task_reg);
    assign switch_hit = (prev_reg != next_reg) && (prev_is || next_is);

    always_comb
    begin
        switch_counter_next = switch_counter_reg;
        run_start_next      = run_start_reg;
        run_accum_next      = run_accum_reg;
        syscall_start_next  = syscall_start_reg;
        in_syscall_next     = in_syscall_reg;
        syscall_accum_next  = syscall_accum_reg;
        user_start_next     = user_start_reg;
        in_user_mode_next   = in_user_mode_reg;
        user_accum_next     = user_accum_reg;
        softirq_start_next  = softirq_start_reg;
        softirq_accum_next  = softirq_accum_reg;
        irq_start_next      = irq_start_reg;
        irq_accum_next      = irq_accum_reg;

        if (op_reg == tta_pkg::OP_SWITCH)
        begin
            if (switch_hit)
            begin
                // prev and next differ, so at most one of them is the target
                if (next_is)
                begin
                    switch_counter_next = switch_counter_reg + TW'(1);
                    run_start_next      = ts_reg;
                end
                if (prev_is)
                begin
                    run_accum_next = run_accum_reg + (ts_reg - run_start_reg);
                end
                if (prev_is && in_syscall_reg)
                begin
                    syscall_accum_next = syscall_accum_reg + (ts_reg - syscall_start_reg);
                end
                if (in_syscall_reg)
                begin
                    syscall_start_next = ts_reg;
                end
                if (prev_is && in_user_mode_reg)
                begin
                    user_accum_next = user_accum_reg + (ts_reg - user_start_reg);
                end
                if (next_is && in_user_mode_reg)
                begin
                    user_start_next = ts_reg;
                end
            end
        end
        else if (cur_is)
        begin
            case (op_reg)
                tta_pkg::OP_SYSCALL_ENTRY:
                begin
                    syscall_start_next = ts_reg;
                    in_syscall_next    = 1'b1;
                    if (in_user_mode_reg)
                    begin
                        user_accum_next = user_accum_reg + (ts_reg - user_start_reg);
                    end
                    user_start_next   = ts_reg;
                    in_user_mode_next = 1'b0;
                end
                tta_pkg::OP_USER_RETURN:
                begin
                    user_start_next   = ts_reg;
                    in_user_mode_next = 1'b1;
                    if (in_syscall_reg)
                    begin
                        syscall_accum_next = syscall_accum_reg + (ts_reg - syscall_start_reg);
                    end
                    syscall_start_next = ts_reg;
                    in_syscall_next    = 1'b0;
                end
                tta_pkg::OP_SOFTIRQ_ENTRY:
                begin
                    softirq_start_next = ts_reg;
                end
                tta_pkg::OP_SOFTIRQ_EXIT:
                begin
                    softirq_accum_next = softirq_accum_reg + (ts_reg - softirq_start_reg);
                end
                tta_pkg::OP_IRQ_ENTRY:
                begin
                    irq_start_next = ts_reg;
                end
                tta_pkg::OP_IRQ_EXIT:
                begin
                    irq_accum_next = irq_accum_reg + (ts_reg - irq_start_reg);
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            switch_counter_reg <= '0;
            run_start_reg      <= '0;
            run_accum_reg      <= '0;
            syscall_start_reg  <= '0;
            in_syscall_reg     <= 1'b0;
            syscall_accum_reg  <= '0;
            user_start_reg     <= '0;
            in_user_mode_reg   <= 1'b0;
            user_accum_reg     <= '0;
            softirq_start_reg  <= '0;
            softirq_accum_reg  <= '0;
            irq_start_reg      <= '0;
            irq_accum_reg      <= '0;
        end
        else if (advance)
        begin
            switch_counter_reg <= switch_counter_next;
            run_start_reg      <= run_start_next;
            run_accum_reg      <= run_accum_next;
            syscall_start_reg  <= syscall_start_next;
            in_syscall_reg     <= in_syscall_next;
            syscall_accum_reg  <= syscall_accum_next;
            user_start_reg     <= user_start_next;
            in_user_mode_reg   <= in_user_mode_next;
            user_accum_reg     <= user_accum_next;
            softirq_start_reg  <= softirq_start_next;
            softirq_accum_reg  <= softirq_accum_next;
            irq_start_reg      <= irq_start_next;
            irq_accum_reg      <= irq_accum_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (advance)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            m_tdata_reg <= {irq_accum_next, softirq_accum_next, user_accum_next,
                            syscall_accum_next, run_accum_next, switch_counter_next};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef SYNTHESIS
    // syscall and user-mode intervals are never open together
    assert property (@(posedge clk) disable iff (!rst_n)
        !(in_syscall_reg && in_user_mode_reg))
        else $error("syscall and user mode both open");

    // a stalled input side means both stages are full and the result is held
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (in_valid_reg && m_tvalid_reg && !m_tready))
        else $error("input stalled without a full pipeline");

    // a switch between identical tasks leaves the run accounting alone
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && (op_reg == tta_pkg::OP_SWITCH) && (prev_reg == next_reg))
        |=> ($stable(switch_counter_reg) && $stable(run_accum_reg)))
        else $error("self switch changed run accounting");

    // every processed event loads a result transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> m_tvalid_reg)
        else $error("processed event produced no result");
`endif

endmodule

`default_nettype wire
